// ===== sv/cka_pkg.sv =====
`default_nettype none
package cka_pkg;

  localparam int ChanW    = 8;
  localparam int SqW      = 2 * ChanW;
  localparam int SumW     = SqW + 2;
  localparam int RadW     = SumW + 8;
  localparam int RootW    = RadW / 2;
  localparam int RemW     = RootW + 2;
  localparam int RadiusW  = 13;
  localparam int FadeW    = 12;
  localparam int ProdW    = ChanW + FadeW;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 13;
  localparam int SqrtCells = RootW;
  localparam int DivCells  = ChanW;

  localparam logic [FadeW-1:0]   FadeMin     = FadeW'(16);
  localparam logic [ChanW-1:0]   KeyRedRst   = ChanW'(0);
  localparam logic [ChanW-1:0]   KeyGreenRst = ChanW'(255);
  localparam logic [ChanW-1:0]   KeyBlueRst  = ChanW'(0);
  localparam logic [RadiusW-1:0] RadiusRst   = RadiusW'(480);
  localparam logic [FadeW-1:0]   FadeRst     = FadeW'(160);

  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY_RED      = 3'd0,
    REG_KEY_GREEN    = 3'd1,
    REG_KEY_BLUE     = 3'd2,
    REG_MATCH_RADIUS = 3'd3,
    REG_FADE_WIDTH   = 3'd4
  } cka_reg_t;

  typedef struct packed {
    logic [ChanW-1:0] in_red;
    logic [ChanW-1:0] in_green;
    logic [ChanW-1:0] in_blue;
    logic [ChanW-1:0] in_alpha;
  } cka_in_t;

  typedef struct packed {
    logic [ChanW-1:0] out_red;
    logic [ChanW-1:0] out_green;
    logic [ChanW-1:0] out_blue;
    logic [ChanW-1:0] out_alpha;
  } cka_out_t;

  // control and pixel that ride along with each word
  typedef struct packed {
    logic    vld;
    logic    bypass;
    cka_in_t pix;
  } cka_tag_t;

  typedef struct packed {
    logic [RadW-1:0]  rad;
    logic [RootW-1:0] root;
    logic [RemW-1:0]  rem;
  } cka_sq_t;

  typedef struct packed {
    logic [ProdW-1:0] rem;
    logic [ChanW-1:0] quo;
  } cka_dv_t;

endpackage
`default_nettype wire

// ===== sv/chroma_key_alpha.sv =====
`default_nettype none
// Chroma key with soft edge on an RGBA pixel stream.
// Input: a pixel word on in_word is taken at each clock edge where start is
// high and busy is low. busy is always low, so a pixel may enter every cycle.
// Output: out_valid strobes for one cycle with the keyed pixel on out_word.
// Color channels pass through; alpha is cleared inside the match radius,
// kept beyond radius plus fade width and scaled linearly in between.
// From the accepting edge to out_valid a pixel passes through, in order:
// a difference-square stage, a sum stage, 13 square-root cells (one root bit
// each), two key stages (compare, then alpha times distance) and 8 divider
// cells (one quotient bit each), then the output register. Throughput is
// one pixel per clock; every stage hands its word on each cycle.
// Configuration: cfg_we writes cfg_wdata to the register at cfg_idx (key red,
// green, blue, match radius, fade width); other indexes are ignored. Write
// only while no pixel is in flight. A fade width below 1.0 acts as 1.0.
// Reset (rst_n low, synchronous) empties the pipeline and restores the
// register defaults. The receiver cannot stall; results must be taken.
module chroma_key_alpha
  import cka_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire cka_in_t             in_word,
  output logic                     out_valid,
  output cka_out_t                 out_word,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_idx,
  input  wire logic [CfgDataW-1:0] cfg_wdata
);

  logic [ChanW-1:0]   key_red_r;
  logic [ChanW-1:0]   key_green_r;
  logic [ChanW-1:0]   key_blue_r;
  logic [RadiusW-1:0] radius_r;
  logic [FadeW-1:0]   fade_r;
  logic [FadeW-1:0]   edge_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_red_r   <= KeyRedRst;
      key_green_r <= KeyGreenRst;
      key_blue_r  <= KeyBlueRst;
      radius_r    <= RadiusRst;
      fade_r      <= FadeRst;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_KEY_RED:      key_red_r   <= cfg_wdata[ChanW-1:0];
        REG_KEY_GREEN:    key_green_r <= cfg_wdata[ChanW-1:0];
        REG_KEY_BLUE:     key_blue_r  <= cfg_wdata[ChanW-1:0];
        REG_MATCH_RADIUS: radius_r    <= cfg_wdata[RadiusW-1:0];
        REG_FADE_WIDTH:   fade_r      <= cfg_wdata[FadeW-1:0];
        default: ;
      endcase
    end
  end

  assign edge_eff = (fade_r < FadeMin) ? FadeMin : fade_r;
  assign busy     = 1'b0;

  // difference squares
  logic [ChanW-1:0] dr, dg, db;
  logic [SqW-1:0]   sq_red_r, sq_green_r, sq_blue_r;
  cka_tag_t         s1_tag_r;

  always_comb begin
    dr = (in_word.in_red > key_red_r) ? in_word.in_red - key_red_r
                                      : key_red_r - in_word.in_red;
    dg = (in_word.in_green > key_green_r) ? in_word.in_green - key_green_r
                                          : key_green_r - in_word.in_green;
    db = (in_word.in_blue > key_blue_r) ? in_word.in_blue - key_blue_r
                                        : key_blue_r - in_word.in_blue;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_tag_r.vld <= 1'b0;
    end else begin
      s1_tag_r.vld <= start && !busy;
    end
    s1_tag_r.bypass <= 1'b0;
    s1_tag_r.pix    <= in_word;
    sq_red_r        <= SqW'(dr) * SqW'(dr);
    sq_green_r      <= SqW'(dg) * SqW'(dg);
    sq_blue_r       <= SqW'(db) * SqW'(db);
  end

  // sum of squares, scaled for 4 fractional root bits
  cka_tag_t sq_tag [SqrtCells+1];
  cka_sq_t  sq_dat [SqrtCells+1];
  cka_tag_t s2_tag_r;
  cka_sq_t  s2_sq_r;
  logic [SumW-1:0] sum;

  assign sum = SumW'(sq_red_r) + SumW'(sq_green_r) + SumW'(sq_blue_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_tag_r.vld <= 1'b0;
    end else begin
      s2_tag_r.vld <= s1_tag_r.vld;
    end
    s2_tag_r.bypass <= s1_tag_r.bypass;
    s2_tag_r.pix    <= s1_tag_r.pix;
    s2_sq_r.rad     <= {sum, 8'b0};
    s2_sq_r.root    <= '0;
    s2_sq_r.rem     <= '0;
  end

  assign sq_tag[0] = s2_tag_r;
  assign sq_dat[0] = s2_sq_r;

  for (genvar i = 0; i < SqrtCells; i++) begin : g_sqrt
    cka_sqrt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .tag_i (sq_tag[i]),
      .sq_i  (sq_dat[i]),
      .tag_o (sq_tag[i+1]),
      .sq_o  (sq_dat[i+1])
    );
  end

  // key stage 1: distance past the radius and region
  logic [RootW-1:0] key_dist;
  logic [RootW:0]   over;
  logic             inside_key;
  logic             past_fade;
  cka_tag_t         k1_tag_r;
  logic [FadeW-1:0] k1_d_r;

  always_comb begin
    key_dist   = sq_dat[SqrtCells].root;
    over       = {1'b0, key_dist} - (RootW+1)'(radius_r);
    inside_key = ((RootW+1)'(key_dist) <= (RootW+1)'(radius_r));
    past_fade  = (over >= (RootW+1)'(edge_eff));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k1_tag_r.vld <= 1'b0;
    end else begin
      k1_tag_r.vld <= sq_tag[SqrtCells].vld;
    end
    k1_tag_r.bypass <= !inside_key && past_fade;
    k1_tag_r.pix    <= sq_tag[SqrtCells].pix;
    k1_d_r          <= (inside_key || past_fade) ? '0 : over[FadeW-1:0];
  end

  // key stage 2: alpha times distance
  cka_tag_t dv_tag [DivCells+1];
  cka_dv_t  dv_dat [DivCells+1];
  cka_tag_t k2_tag_r;
  cka_dv_t  k2_dv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k2_tag_r.vld <= 1'b0;
    end else begin
      k2_tag_r.vld <= k1_tag_r.vld;
    end
    k2_tag_r.bypass <= k1_tag_r.bypass;
    k2_tag_r.pix    <= k1_tag_r.pix;
    k2_dv_r.rem     <= ProdW'(k1_tag_r.pix.in_alpha) * ProdW'(k1_d_r);
    k2_dv_r.quo     <= '0;
  end

  assign dv_tag[0] = k2_tag_r;
  assign dv_dat[0] = k2_dv_r;

  for (genvar j = 0; j < DivCells; j++) begin : g_div
    cka_div_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .edge_i (edge_eff),
      .tag_i  (dv_tag[j]),
      .dv_i   (dv_dat[j]),
      .tag_o  (dv_tag[j+1]),
      .dv_o   (dv_dat[j+1])
    );
  end

  // output register
  cka_tag_t   last_tag;
  logic       out_valid_r;
  cka_out_t   out_word_r;

  assign last_tag = dv_tag[DivCells];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= last_tag.vld;
    end
    out_word_r.out_red   <= last_tag.pix.in_red;
    out_word_r.out_green <= last_tag.pix.in_green;
    out_word_r.out_blue  <= last_tag.pix.in_blue;
    out_word_r.out_alpha <= last_tag.bypass ? last_tag.pix.in_alpha
                                            : dv_dat[DivCells].quo;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // root remainder never exceeds twice the root
  a_sqrt_rem: assert property (@(posedge clk) disable iff (!rst_n)
    sq_tag[SqrtCells].vld |->
      ({1'b0, sq_dat[SqrtCells].rem} <= {sq_dat[SqrtCells].root, 1'b0}))
    else $error("square root remainder out of range");

  // scaled alpha never exceeds the incoming alpha
  a_quo_le_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    (last_tag.vld && !last_tag.bypass) |->
      (dv_dat[DivCells].quo <= last_tag.pix.in_alpha))
    else $error("scaled alpha above input alpha");

  // divider remainder stays below the divisor after the last step
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    last_tag.vld |-> (dv_dat[DivCells].rem < ProdW'({edge_eff, DivCells'(0)})))
    else $error("divider remainder out of range");

  // the scaled product never reaches 256 times the edge
  a_prod_range: assert property (@(posedge clk) disable iff (!rst_n)
    k2_tag_r.vld |-> (k2_dv_r.rem < ProdW'({edge_eff, DivCells'(0)})))
    else $error("alpha product too large for the divider");

endmodule
`default_nettype wire

// ===== sv/cka_sqrt_cell.sv =====
`default_nettype none
module cka_sqrt_cell
  import cka_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire cka_tag_t tag_i,
  input  wire cka_sq_t  sq_i,
  output cka_tag_t      tag_o,
  output cka_sq_t       sq_o
);

  logic [RemW+1:0] acc;
  logic [RemW+1:0] test;
  logic            ge;
  logic [RemW+1:0] diff;
  cka_sq_t         sq_nxt;
  cka_tag_t        tag_r;
  cka_sq_t         sq_r;

  // one root bit per cell: bring down two radicand bits, try (root<<2)|1
  always_comb begin
    acc  = {sq_i.rem, sq_i.rad[RadW-1 -: 2]};
    test = (RemW+2)'({sq_i.root, 2'b01});
    ge   = (acc >= test);
    diff = acc - test;
    sq_nxt.rem  = ge ? diff[RemW-1:0] : acc[RemW-1:0];
    sq_nxt.root = {sq_i.root[RootW-2:0], ge};
    sq_nxt.rad  = {sq_i.rad[RadW-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r.vld <= 1'b0;
    end else begin
      tag_r.vld <= tag_i.vld;
    end
    tag_r.bypass <= tag_i.bypass;
    tag_r.pix    <= tag_i.pix;
    sq_r         <= sq_nxt;
  end

  assign tag_o = tag_r;
  assign sq_o  = sq_r;

endmodule
`default_nettype wire

// ===== sv/cka_div_cell.sv =====
`default_nettype none
module cka_div_cell
  import cka_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [FadeW-1:0] edge_i,
  input  wire cka_tag_t         tag_i,
  input  wire cka_dv_t          dv_i,
  output cka_tag_t              tag_o,
  output cka_dv_t               dv_o
);

  logic [ProdW-1:0] shifted;
  logic             ge;
  logic [ProdW-1:0] diff;
  cka_dv_t          dv_nxt;
  cka_tag_t         tag_r;
  cka_dv_t          dv_r;

  // restoring step against the divisor aligned to the top quotient bit
  always_comb begin
    shifted    = ProdW'({edge_i, {(DivCells-1){1'b0}}});
    ge         = (dv_i.rem >= shifted);
    diff       = dv_i.rem - shifted;
    dv_nxt.rem = ge ? {diff[ProdW-2:0], 1'b0} : {dv_i.rem[ProdW-2:0], 1'b0};
    dv_nxt.quo = {dv_i.quo[ChanW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r.vld <= 1'b0;
    end else begin
      tag_r.vld <= tag_i.vld;
    end
    tag_r.bypass <= tag_i.bypass;
    tag_r.pix    <= tag_i.pix;
    dv_r         <= dv_nxt;
  end

  assign tag_o = tag_r;
  assign dv_o  = dv_r;

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import cka_pkg::*;

  localparam int WatchdogLimit = 4000;
  localparam int RandomPhases = 8;
  localparam int PixelsPerPhase = 130;
  localparam int DrainCycles = 40;
  localparam int ReportLimit = 10;
  localparam logic [CfgIdxW-1:0] SpareIdxFirst = 3'd5;

  // keeps its own copy of the key registers and the words still to come out
  class alpha_key_tracker;
    logic [ChanW-1:0] key_r;
    logic [ChanW-1:0] key_g;
    logic [ChanW-1:0] key_b;
    logic [RadiusW-1:0] radius;
    logic [FadeW-1:0] fade;
    cka_out_t keyed_q[$];
    int mismatches;
    int pixels;
    int cleared;
    int faded;
    int kept;

    function new();
      key_r = KeyRedRst;
      key_g = KeyGreenRst;
      key_b = KeyBlueRst;
      radius = RadiusRst;
      fade = FadeRst;
      mismatches = 0;
      pixels = 0;
      cleared = 0;
      faded = 0;
      kept = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        REG_KEY_RED:      key_r = data[ChanW-1:0];
        REG_KEY_GREEN:    key_g = data[ChanW-1:0];
        REG_KEY_BLUE:     key_b = data[ChanW-1:0];
        REG_MATCH_RADIUS: radius = data[RadiusW-1:0];
        REG_FADE_WIDTH:   fade = data[FadeW-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned root_floor(int unsigned v);
      int unsigned r;
      int unsigned trial;
      r = 0;
      for (int i = RootW - 1; i >= 0; i--) begin
        trial = r | (32'd1 << i);
        if (trial * trial <= v) r = trial;
      end
      return r;
    endfunction

    function int unsigned sq_gap(logic [ChanW-1:0] a, logic [ChanW-1:0] b);
      int unsigned d;
      d = (a > b) ? int'(a - b) : int'(b - a);
      return d * d;
    endfunction

    function cka_out_t keyed_pixel(cka_in_t px);
      cka_out_t res;
      int unsigned key_dist;
      int unsigned gap;
      int unsigned span;
      key_dist = root_floor((sq_gap(px.in_red, key_r) + sq_gap(px.in_green, key_g)
                             + sq_gap(px.in_blue, key_b)) * 256);
      span = (fade < FadeMin) ? int'(FadeMin) : int'(fade);
      res.out_red = px.in_red;
      res.out_green = px.in_green;
      res.out_blue = px.in_blue;
      if (key_dist <= radius) begin
        res.out_alpha = '0;
        cleared++;
      end else begin
        gap = key_dist - radius;
        if (gap >= span) begin
          res.out_alpha = px.in_alpha;
          kept++;
        end else begin
          res.out_alpha = ChanW'((int'(px.in_alpha) * gap) / span);
          faded++;
        end
      end
      return res;
    endfunction

    function void note_pixel(cka_in_t px);
      keyed_q = {keyed_q, keyed_pixel(px)};
      pixels++;
    endfunction

    function void check_pixel(cka_out_t got);
      cka_out_t want;
      logic bad;
      if (keyed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit) $display("output word %h with none pending", got);
        return;
      end
      want = keyed_q.pop_front();
      bad = (got.out_red !== want.out_red) | (got.out_green !== want.out_green)
          | (got.out_blue !== want.out_blue) | (got.out_alpha !== want.out_alpha);
      if (bad) begin
        mismatches++;
        if (mismatches <= ReportLimit) begin
          $display("word mismatch: expected r=%0d g=%0d b=%0d a=%0d, got r=%0d g=%0d b=%0d a=%0d",
                   want.out_red, want.out_green, want.out_blue, want.out_alpha,
                   got.out_red, got.out_green, got.out_blue, got.out_alpha);
        end
      end
    endfunction

    function void finish_check();
      if (keyed_q.size() != 0) begin
        $display("%0d expected words never came out", keyed_q.size());
        mismatches += keyed_q.size();
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  cka_in_t in_word;
  logic out_valid;
  cka_out_t out_word;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;

  alpha_key_tracker book;
  bit idle_en;
  int settings_used;

  chroma_key_alpha u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) book.check_pixel(out_word);
  end

  initial begin : watchdog
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < WatchdogLimit) begin
      @(posedge clk);
      if ((start === 1'b1 && busy === 1'b0) || out_valid === 1'b1) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("watchdog: no word moved for %0d cycles", WatchdogLimit);
    $display("chroma_key_alpha: mismatch");
    $finish;
  end

  // called at a falling edge, returns at a falling edge with start still high
  task automatic send_pixel(input cka_in_t px);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    start <= 1'b1;
    in_word <= px;
    do @(posedge clk); while (busy !== 1'b0);
    book.note_pixel(px);
    @(negedge clk);
  endtask

  task automatic send_rgba(input int r, input int g, input int b, input int a);
    send_pixel(cka_in_t'{ChanW'(r), ChanW'(g), ChanW'(b), ChanW'(a)});
  endtask

  task automatic drive_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    book.write_reg(idx, data);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (book.keyed_q.size() != 0) @(negedge clk);
  endtask

  // upper bits beyond each register's width carry junk that must be dropped
  task automatic apply_settings(input int kr, input int kg, input int kb,
                                input int rad, input int fw);
    drain();
    drive_reg(REG_KEY_RED, (CfgDataW'($urandom) << ChanW) | CfgDataW'(kr));
    drive_reg(REG_KEY_GREEN, (CfgDataW'($urandom) << ChanW) | CfgDataW'(kg));
    drive_reg(REG_KEY_BLUE, (CfgDataW'($urandom) << ChanW) | CfgDataW'(kb));
    drive_reg(REG_MATCH_RADIUS, CfgDataW'(rad));
    drive_reg(REG_FADE_WIDTH, (CfgDataW'($urandom) << FadeW) | CfgDataW'(fw));
    for (int i = SpareIdxFirst; i < (1 << CfgIdxW); i++) begin
      drive_reg(CfgIdxW'(i), CfgDataW'($urandom));
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [ChanW-1:0] nudge(logic [ChanW-1:0] base, int reach);
    int v;
    v = int'(base) + int'($urandom_range(0, 2 * reach)) - reach;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return ChanW'(v);
  endfunction

  // lands around the radius and across the soft edge most of the time
  function automatic cka_in_t near_key_pixel();
    cka_in_t px;
    int reach;
    reach = ((int'(book.radius) + int'(book.fade)) / 16) * 2 / 3 + 2;
    if (reach > 255) reach = 255;
    px.in_red = nudge(book.key_r, reach);
    px.in_green = nudge(book.key_g, reach);
    px.in_blue = nudge(book.key_b, reach);
    px.in_alpha = ChanW'($urandom);
    return px;
  endfunction

  initial begin
    int kr;
    int kg;
    int kb;
    int rad;
    int fw;
    book = new();
    rst_n = 1'b0;
    start = 1'b0;
    in_word = '0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    idle_en = 1'b1;
    settings_used = 1;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset key: pure green, radius 30.0, edge 10.0
    send_rgba(0, 255, 0, 255);
    send_rgba(30, 255, 0, 255);
    send_rgba(31, 255, 0, 255);
    send_rgba(35, 255, 0, 200);
    send_rgba(40, 255, 0, 255);
    send_rgba(255, 0, 255, 255);
    send_rgba(0, 0, 0, 0);
    send_rgba(255, 255, 255, 255);
    send_rgba(255, 255, 255, 0);
    send_rgba(85, 170, 85, 170);
    send_rgba(170, 85, 170, 85);

    // zero radius with the narrowest edge
    apply_settings(255, 255, 255, 0, 16);
    send_rgba(255, 255, 255, 255);
    send_rgba(254, 255, 255, 255);
    send_rgba(0, 0, 0, 255);

    // edge below 1.0 acts as 1.0
    apply_settings(255, 255, 255, 0, 0);
    send_rgba(254, 255, 255, 200);
    send_rgba(255, 255, 255, 77);
    apply_settings(255, 255, 255, 8, 15);
    send_rgba(255, 255, 254, 123);

    // thresholds past every reachable distance, then a small radius with a wide edge
    apply_settings(0, 0, 0, 8191, 4095);
    send_rgba(255, 255, 255, 255);
    send_rgba(0, 0, 0, 255);
    apply_settings(0, 0, 0, 7072, 3200);
    send_rgba(255, 255, 255, 255);
    apply_settings(0, 0, 0, 16, 3200);
    send_rgba(255, 255, 255, 255);
    send_rgba(128, 0, 0, 255);
    send_rgba(128, 0, 0, 1);

    for (int p = 0; p < RandomPhases; p++) begin
      kr = $urandom_range(0, 255);
      kg = $urandom_range(0, 255);
      kb = $urandom_range(0, 255);
      case ($urandom_range(0, 2))
        0: rad = $urandom_range(0, 800);
        1: rad = $urandom_range(0, 7072);
        default: rad = $urandom_range(0, 3000);
      endcase
      case ($urandom_range(0, 2))
        0: fw = $urandom_range(16, 400);
        1: fw = $urandom_range(16, 3200);
        default: fw = $urandom_range(16, 1200);
      endcase
      case (p)
        0: begin
          kr = 0; kg = 0; kb = 0; rad = 0; fw = 16;
        end
        1: begin
          kr = 255; kg = 255; kb = 255; rad = 7072; fw = 3200;
        end
        2: begin
          rad = $urandom_range(7073, 8191);
          fw = $urandom_range(3201, 4095);
        end
        3: fw = $urandom_range(0, 15);
        4: fw = $urandom_range(3201, 4095);
        default: ;
      endcase
      apply_settings(kr, kg, kb, rad, fw);
      // the last stretch runs back to back
      if (p == RandomPhases - 1) idle_en = 1'b0;
      for (int n = 0; n < PixelsPerPhase; n++) begin
        if ($urandom_range(0, 1) == 0) send_pixel(near_key_pixel());
        else send_pixel(cka_in_t'($urandom));
      end
    end

    drain();
    repeat (DrainCycles) @(negedge clk);
    book.finish_check();
    $display("%0d pixels through %0d register settings, %0d mismatches",
             book.pixels, settings_used, book.mismatches);
    $display("alpha cleared %0d, faded on the soft edge %0d, kept %0d",
             book.cleared, book.faded, book.kept);
    if (book.mismatches == 0) begin
      $display("chroma_key_alpha: match");
    end else begin
      $display("chroma_key_alpha: mismatch");
    end
    $finish;
  end
endmodule
